[rtl/core/svtm_pkg.sv]
// Shared constants, codes, widths and rounding helper for the SVPWM
// third-harmonic modulator. No dependencies.
package svtm_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int VOLTAGE_BITS = 16;

    // internal datapath widths
    localparam int AW    = (VOLTAGE_BITS > 16) ? VOLTAGE_BITS : 16;
    localparam int VW    = AW + 2;
    localparam int TW    = VW + 17;
    localparam int PW    = TW + 17;
    localparam int FW    = AW + 5;
    localparam int VT_W  = 20;
    localparam int SUM_W = FW + 1;
    localparam int NUM_W = AW + 2;

    // pipeline depths of the sub-units
    localparam int TRIG_LAT   = 5;
    localparam int ISQ_STEPS  = 17;
    localparam int ISQ_STAGES = (ISQ_STEPS + 1) / 2;
    localparam int DIV_BITS   = 16;
    localparam int DIV_STAGES = DIV_BITS / 2;

    typedef enum logic [1:0] {
        OP_DQ  = 2'd0,
        OP_AB  = 2'd1,
        OP_MAG = 2'd2,
        OP_RSV = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        REG_SUPPLY     = 2'd0,
        REG_FULL_SCALE = 2'd1,
        REG_FUND_GAIN  = 2'd2,
        REG_HARM_GAIN  = 2'd3
    } t_reg_idx;

    localparam logic [14:0] RST_SUPPLY     = 15'd32767;
    localparam logic [15:0] RST_FULL_SCALE = 16'd1023;
    localparam logic [15:0] RST_FUND_GAIN  = 16'd18919;
    localparam logic [15:0] RST_HARM_GAIN  = 16'd2731;

    localparam logic signed [15:0] K_TWO_THIRDS = 16'sd10923;
    localparam logic signed [15:0] K_ONE_THIRD  = 16'sd5461;
    localparam logic signed [15:0] K_INV_ROOT3  = 16'sd9459;

    localparam logic [14:0] SIN_A   = 15'd25736;
    localparam logic [13:0] SIN_B   = 14'd10512;
    localparam logic [10:0] SIN_C   = 11'd1160;
    localparam logic [15:0] QUARTER = 16'd16384;
    localparam logic [15:0] THREE_Q = 16'd49152;
    localparam logic [15:0] MAG_CAP = 16'hFFFF;

    // shift right by n, rounding half away from zero
    function automatic logic signed [63:0] round_sh(input logic signed [63:0] v, input int n);
        logic signed [63:0] h;
        logic signed [63:0] c;
        h = 64'sd1 <<< (n - 1);
        c = v[63] ? 64'sd1 : 64'sd0;
        return (v + h - c) >>> n;
    endfunction

endpackage

[rtl/core/svtm_trig.sv]
// Pipelined Q14 sine from a 16-bit turn fraction (quarter-wave polynomial).
// Depends on svtm_pkg.
module svtm_trig import svtm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [15:0]        i_angle,
    output logic signed [15:0] o_sin
);

    logic [14:0]        r_a_z, r_b_z, r_c_z, r_d_z;
    logic               r_a_neg, r_b_neg, r_c_neg, r_d_neg;
    logic [14:0]        r_b_z2, r_c_z2;
    logic [10:0]        r_c_t;
    logic [13:0]        r_d_t;
    logic signed [15:0] r_e;

    logic [14:0] w_z;
    logic [29:0] w_zz;
    logic [25:0] w_ct;
    logic [28:0] w_dt;
    logic [29:0] w_et;
    logic [15:0] w_e;

    always_comb begin
        w_z  = i_angle[14] ? 15'(15'd16384 - {1'b0, i_angle[13:0]}) : {1'b0, i_angle[13:0]};
        w_zz = 30'(r_a_z * r_a_z);
        w_ct = 26'(SIN_C * r_b_z2);
        w_dt = 29'((SIN_B - 14'(r_c_t)) * r_c_z2);
        w_et = 30'((SIN_A - 15'(r_d_t)) * r_d_z);
        w_e  = 16'(w_et >> 14);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_z   <= w_z;
            r_a_neg <= i_angle[15];
            r_b_z   <= r_a_z;
            r_b_neg <= r_a_neg;
            r_b_z2  <= 15'(w_zz >> 14);
            r_c_z   <= r_b_z;
            r_c_neg <= r_b_neg;
            r_c_z2  <= r_b_z2;
            r_c_t   <= 11'(w_ct >> 14);
            r_d_z   <= r_c_z;
            r_d_neg <= r_c_neg;
            r_d_t   <= 14'(w_dt >> 14);
            r_e     <= r_d_neg ? -$signed(w_e) : $signed(w_e);
        end
    end

    assign o_sin = r_e;

endmodule

[rtl/core/svtm_isqrt.sv]
// Pipelined floor square root of a 33-bit radicand, two result bits per stage (one in the last stage).
// Depends on svtm_pkg.
module svtm_isqrt import svtm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_rad,
    output logic [16:0] o_root
);

    logic [19:0] r_rem  [0:ISQ_STAGES-1];
    logic [16:0] r_root [0:ISQ_STAGES-1];
    logic [33:0] r_rad  [0:ISQ_STAGES-1];
    logic [19:0] w_rem  [0:ISQ_STAGES-1];
    logic [16:0] w_root [0:ISQ_STAGES-1];
    logic [33:0] w_rad  [0:ISQ_STAGES-1];

    always_comb begin
        logic [19:0] x;
        logic [19:0] trial;
        logic [19:0] rem;
        logic [16:0] root;
        logic [33:0] rad;
        for (int s = 0; s < ISQ_STAGES; s++) begin
            if (s == 0) begin
                rem  = '0;
                root = '0;
                rad  = {1'b0, i_rad};
            end else begin
                rem  = r_rem[s-1];
                root = r_root[s-1];
                rad  = r_rad[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                if (s * 2 + j < ISQ_STEPS) begin
                    x     = {rem[17:0], rad[33:32]};
                    trial = {1'b0, root, 2'b01};
                    rad   = {rad[31:0], 2'b00};
                    if (x >= trial) begin
                        rem  = x - trial;
                        root = {root[15:0], 1'b1};
                    end else begin
                        rem  = x;
                        root = {root[15:0], 1'b0};
                    end
                end
            end
            w_rem[s]  = rem;
            w_root[s] = root;
            w_rad[s]  = rad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_rem;
            r_root <= w_root;
            r_rad  <= w_rad;
        end
    end

    assign o_root = r_root[ISQ_STAGES-1];

endmodule

[rtl/core/svtm_div.sv]
// Pipelined restoring divider for the duty quotient, two quotient bits per stage.
// Quotient is valid when it fits 16 bits. Depends on svtm_pkg.
module svtm_div import svtm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [32:0]         i_num,
    input  logic [15:0]         i_den,
    output logic [DIV_BITS-1:0] o_quo
);

    logic [16:0]         r_rem [0:DIV_STAGES-1];
    logic [15:0]         r_low [0:DIV_STAGES-1];
    logic [DIV_BITS-1:0] r_quo [0:DIV_STAGES-1];
    logic [16:0]         w_rem [0:DIV_STAGES-1];
    logic [15:0]         w_low [0:DIV_STAGES-1];
    logic [DIV_BITS-1:0] w_quo [0:DIV_STAGES-1];

    always_comb begin
        logic [17:0]         x;
        logic [16:0]         rem;
        logic [15:0]         low;
        logic [DIV_BITS-1:0] quo;
        for (int s = 0; s < DIV_STAGES; s++) begin
            if (s == 0) begin
                rem = i_num[32:16];
                low = i_num[15:0];
                quo = '0;
            end else begin
                rem = r_rem[s-1];
                low = r_low[s-1];
                quo = r_quo[s-1];
            end
            for (int j = 0; j < 2; j++) begin
                x   = {rem, low[15]};
                low = {low[14:0], 1'b0};
                if (x >= {2'b00, i_den}) begin
                    x   = x - {2'b00, i_den};
                    quo = {quo[DIV_BITS-2:0], 1'b1};
                end else begin
                    quo = {quo[DIV_BITS-2:0], 1'b0};
                end
                rem = x[16:0];
            end
            w_rem[s] = rem;
            w_low[s] = low;
            w_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_rem;
            r_low <= w_low;
            r_quo <= w_quo;
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];

endmodule

[rtl/core/svpwm_third_harmonic_modulator_unit.sv]
// Top level of the SVPWM modulator with third-harmonic injection.
// Depends on svtm_pkg, svtm_trig, svtm_isqrt, svtm_div.
//
// One transfer is taken every clock unless the output is stalled; each result is held
// in place while the output is stalled (a stall freezes the whole pipeline). Depth
// is set by the four-multiply sine pipelines, the square root
// (two bits per stage) and the duty divider (two bits per stage). Registers sit on
// the APB port at byte addresses 0, 4, 8, 12 and may only be written while no
// transfer is in flight. No clearing pass after reset.
module svpwm_third_harmonic_modulator_unit import svtm_pkg::*; (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_opcode,
    input  logic signed [VOLTAGE_BITS-1:0] i_first_component,
    input  logic signed [VOLTAGE_BITS-1:0] i_second_component,
    input  logic [ANGLE_BITS-1:0]          i_angle,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [VOLTAGE_BITS-1:0] o_phase_a_voltage,
    output logic signed [VOLTAGE_BITS-1:0] o_phase_b_voltage,
    output logic signed [VOLTAGE_BITS-1:0] o_phase_c_voltage,
    output logic [15:0]                    o_duty_a,
    output logic [15:0]                    o_duty_b,
    output logic [15:0]                    o_duty_c,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int S_SQ  = TRIG_LAT + 4;
    localparam int S_FND = S_SQ + 2;
    localparam int S_MAG = S_SQ + ISQ_STAGES;
    localparam int S_VR  = S_MAG + 1;
    localparam int S_HP  = S_VR + 1;
    localparam int S_VT  = S_VR + 3;
    localparam int S_V   = S_VT + 1;
    localparam int S_FL  = S_V + 1;
    localparam int S_N   = S_FL + 1;
    localparam int S_Q   = S_N + DIV_STAGES;
    localparam int S_OUT = S_Q + 1;
    localparam int DA    = TRIG_LAT;
    localparam int DB    = ISQ_STAGES;
    localparam int DC    = S_HP - TRIG_LAT;
    localparam int DD    = S_VT - S_FND;
    localparam int DE    = S_Q - S_V;
    localparam int DF    = S_Q - S_FL;
    localparam longint VMAX_L = (64'sd1 <<< (VOLTAGE_BITS - 1)) - 64'sd1;
    localparam longint VMIN_L = -VMAX_L - 64'sd1;

    typedef struct packed {
        logic [1:0]                     op;
        logic signed [VOLTAGE_BITS-1:0] f;
        logic signed [VOLTAGE_BITS-1:0] s;
        logic [14:0]                    vr2;
    } t_front;

    typedef struct packed {
        logic        mag;
        logic [14:0] vr2;
    } t_polar;

    typedef struct packed {
        logic zero;
        logic full;
    } t_flags;

    // configuration
    logic [14:0] r_supply;
    logic [15:0] r_full_scale, r_fund_gain, r_harm_gain;
    logic [14:0] w_vs;
    logic [15:0] w_den;
    logic        w_cfg_wr;

    assign w_cfg_wr = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign w_vs     = (r_supply == 15'd0) ? 15'd1 : r_supply;
    assign w_den    = {w_vs, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply     <= RST_SUPPLY;
            r_full_scale <= RST_FULL_SCALE;
            r_fund_gain  <= RST_FUND_GAIN;
            r_harm_gain  <= RST_HARM_GAIN;
        end else if (w_cfg_wr) begin
            case (t_reg_idx'(paddr[3:2]))
                REG_SUPPLY:     r_supply     <= pwdata[14:0];
                REG_FULL_SCALE: r_full_scale <= pwdata[15:0];
                REG_FUND_GAIN:  r_fund_gain  <= pwdata[15:0];
                REG_HARM_GAIN:  r_harm_gain  <= pwdata[15:0];
                default:        r_supply     <= r_supply;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[3:2]))
            REG_SUPPLY:     prdata = 32'(r_supply);
            REG_FULL_SCALE: prdata = 32'(r_full_scale);
            REG_FUND_GAIN:  prdata = 32'(r_fund_gain);
            REG_HARM_GAIN:  prdata = 32'(r_harm_gain);
            default:        prdata = '0;
        endcase
    end

    // flow control
    logic         w_en;
    logic [S_OUT:0] r_vld;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[S_OUT-1:0], i_valid};
        end
    end

    // stage 0
    logic [ANGLE_BITS+15:0] w_ang_ext;
    logic [15:0]            w_u;
    logic [14:0]            w_vr2;
    t_front                 r0;
    logic [15:0]            r0_u;

    assign w_ang_ext = {i_angle, 16'b0};
    assign w_u       = w_ang_ext[ANGLE_BITS+15 -: 16];

    always_comb begin
        if (i_first_component < 0) begin
            w_vr2 = '0;
        end else if (i_first_component > $signed({2'b00, w_vs})) begin
            w_vr2 = w_vs;
        end else begin
            w_vr2 = 15'(i_first_component);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0.op  <= i_opcode;
            r0.f   <= i_first_component;
            r0.s   <= i_second_component;
            r0.vr2 <= w_vr2;
            r0_u   <= w_u;
        end
    end

    // trig
    logic signed [15:0] w_sin, w_cos, w_ncos3;

    svtm_trig u_sin (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (r0_u),
        .o_sin   (w_sin)
    );

    svtm_trig u_cos (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (16'(r0_u + QUARTER)),
        .o_sin   (w_cos)
    );

    svtm_trig u_h3 (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (16'(r0_u + {r0_u[14:0], 1'b0} + THREE_Q)),
        .o_sin   (w_ncos3)
    );

    t_front r_dla [0:DA-1];

    // stage 6: rotation products
    logic                   w6_mag, w6_rot;
    logic signed [AW-1:0]   w6_a, w6_b;
    logic signed [AW+15:0]  r6_p1, r6_p2, r6_p3, r6_p4;
    logic                   r6_mag, r6_rot;
    logic signed [VOLTAGE_BITS-1:0] r6_f, r6_s;
    logic [14:0]            r6_vr2;

    always_comb begin
        w6_mag = (t_opcode'(r_dla[DA-1].op) == OP_MAG);
        w6_rot = (t_opcode'(r_dla[DA-1].op) == OP_DQ) || w6_mag;
        w6_a   = w6_mag ? $signed(AW'(r_dla[DA-1].vr2)) : AW'(r_dla[DA-1].f);
        w6_b   = w6_mag ? '0 : AW'(r_dla[DA-1].s);
    end

    // stage 7
    logic signed [AW+16:0] w7_d1, w7_d2;
    logic signed [VW-1:0]  r7_vx, r7_vy;
    logic                  r7_mag;
    logic [14:0]           r7_vr2;

    assign w7_d1 = (AW+17)'(r6_p1) - (AW+17)'(r6_p2);
    assign w7_d2 = (AW+17)'(r6_p3) + (AW+17)'(r6_p4);

    // stage 8
    logic [VW-1:0]         w8_ax, w8_ay;
    logic [15:0]           w8_cx, w8_cy;
    logic [31:0]           r8_sqx, r8_sqy;
    logic signed [VW+14:0] r8_t0, r8_t1a, r8_t1b;
    logic                  r8_mag;
    logic [14:0]           r8_vr2;

    always_comb begin
        w8_ax = r7_vx[VW-1] ? VW'(-r7_vx) : VW'(r7_vx);
        w8_ay = r7_vy[VW-1] ? VW'(-r7_vy) : VW'(r7_vy);
        w8_cx = (w8_ax > VW'(MAG_CAP)) ? MAG_CAP : w8_ax[15:0];
        w8_cy = (w8_ay > VW'(MAG_CAP)) ? MAG_CAP : w8_ay[15:0];
    end

    // stage 9
    logic signed [TW-1:0] w9_term [0:2];
    logic signed [TW-1:0] r9_term [0:2];
    logic [32:0]          r9_sum;
    t_polar               r9_pol;

    always_comb begin
        w9_term[0] = TW'(r8_t0);
        w9_term[1] = TW'(r8_t1a) - TW'(r8_t1b);
        w9_term[2] = -TW'(r8_t0) - w9_term[1];
    end

    // stages 10, 11: fundamental gain
    logic signed [PW-1:0] r10_p [0:2];
    logic signed [FW-1:0] r11_fund [0:2];

    // magnitude
    logic [16:0] w_mag;
    t_polar      r_dlb [0:DB-1];

    svtm_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r9_sum),
        .o_root (w_mag)
    );

    // harmonic path
    logic [14:0]            r19_vr;
    logic [30:0]            r20_hp;
    logic signed [47:0]     r21_hq;
    logic signed [VT_W-1:0] r22_vt;
    logic signed [15:0]     r_dlc [0:DC-1];
    logic signed [FW-1:0]   r_dld [0:DD-1][0:2];

    // phase sum and saturate
    logic signed [SUM_W-1:0]        w23_sum [0:2];
    logic signed [VOLTAGE_BITS-1:0] w23_v   [0:2];
    logic signed [VOLTAGE_BITS-1:0] r23_v   [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w23_sum[k] = SUM_W'(r_dld[DD-1][k]) + SUM_W'(r22_vt);
            if (w23_sum[k] > $signed(SUM_W'(VMAX_L))) begin
                w23_v[k] = VOLTAGE_BITS'(VMAX_L);
            end else if (w23_sum[k] < $signed(SUM_W'(VMIN_L))) begin
                w23_v[k] = VOLTAGE_BITS'(VMIN_L);
            end else begin
                w23_v[k] = VOLTAGE_BITS'(w23_sum[k]);
            end
        end
    end

    // duty numerator
    logic signed [NUM_W-1:0] w24_num [0:2];
    t_flags                  r24_fl  [0:2];
    logic [31:0]             r24_prod [0:2];
    logic [32:0]             r25_n    [0:2];
    logic signed [VOLTAGE_BITS-1:0] r_dle [0:DE-1][0:2];
    t_flags                  r_dlf [0:DF-1][0:2];
    logic [DIV_BITS-1:0]     w_quo [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w24_num[k] = $signed({{(NUM_W-15){1'b0}}, w_vs}) - NUM_W'(r23_v[k]);
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        svtm_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r25_n[g]),
            .i_den (w_den),
            .o_quo (w_quo[g])
        );
    end

    // output register
    logic signed [VOLTAGE_BITS-1:0] r_out_v    [0:2];
    logic [15:0]                    r_out_duty [0:2];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dla[0] <= r0;
            for (int i = 1; i < DA; i++) r_dla[i] <= r_dla[i-1];

            r6_p1  <= w6_a * w_cos;
            r6_p2  <= w6_b * w_sin;
            r6_p3  <= w6_a * w_sin;
            r6_p4  <= w6_b * w_cos;
            r6_mag <= w6_mag;
            r6_rot <= w6_rot;
            r6_f   <= r_dla[DA-1].f;
            r6_s   <= r_dla[DA-1].s;
            r6_vr2 <= r_dla[DA-1].vr2;

            r7_vx  <= r6_rot ? VW'(round_sh(64'(w7_d1), 14)) : VW'(r6_f);
            r7_vy  <= r6_rot ? VW'(round_sh(64'(w7_d2), 14)) : VW'(r6_s);
            r7_mag <= r6_mag;
            r7_vr2 <= r6_vr2;

            r8_sqx <= 32'(w8_cx * w8_cx);
            r8_sqy <= 32'(w8_cy * w8_cy);
            r8_t0  <= K_TWO_THIRDS * r7_vx;
            r8_t1a <= K_INV_ROOT3 * r7_vy;
            r8_t1b <= K_ONE_THIRD * r7_vx;
            r8_mag <= r7_mag;
            r8_vr2 <= r7_vr2;

            r9_sum     <= 33'(r8_sqx) + 33'(r8_sqy);
            r9_term    <= w9_term;
            r9_pol.mag <= r8_mag;
            r9_pol.vr2 <= r8_vr2;

            for (int k = 0; k < 3; k++) begin
                r10_p[k]    <= r9_term[k] * $signed({1'b0, r_fund_gain});
                r11_fund[k] <= FW'(round_sh(64'(r10_p[k]), 28));
            end

            r_dlb[0] <= r9_pol;
            for (int i = 1; i < DB; i++) r_dlb[i] <= r_dlb[i-1];

            if (r_dlb[DB-1].mag) begin
                r19_vr <= r_dlb[DB-1].vr2;
            end else if (w_mag > {2'b00, w_vs}) begin
                r19_vr <= w_vs;
            end else begin
                r19_vr <= w_mag[14:0];
            end

            r_dlc[0] <= w_ncos3;
            for (int i = 1; i < DC; i++) r_dlc[i] <= r_dlc[i-1];

            r20_hp <= 31'(r19_vr * r_harm_gain);
            r21_hq <= $signed({1'b0, r20_hp}) * r_dlc[DC-1];
            r22_vt <= VT_W'(round_sh(64'(r21_hq), 28));

            r_dld[0] <= r11_fund;
            for (int i = 1; i < DD; i++) r_dld[i] <= r_dld[i-1];

            r23_v <= w23_v;

            for (int k = 0; k < 3; k++) begin
                r24_fl[k].zero <= (w24_num[k] <= 0);
                r24_fl[k].full <= (w24_num[k] >= $signed({{(NUM_W-16){1'b0}}, w_den}));
                r24_prod[k]    <= 32'(w24_num[k][15:0] * r_full_scale);
                r25_n[k]       <= 33'(r24_prod[k]) + 33'(w_vs);
            end

            r_dle[0] <= r23_v;
            for (int i = 1; i < DE; i++) r_dle[i] <= r_dle[i-1];
            r_dlf[0] <= r24_fl;
            for (int i = 1; i < DF; i++) r_dlf[i] <= r_dlf[i-1];

            for (int k = 0; k < 3; k++) begin
                r_out_v[k] <= r_dle[DE-1][k];
                if (r_dlf[DF-1][k].zero) begin
                    r_out_duty[k] <= '0;
                end else if (r_dlf[DF-1][k].full || (w_quo[k] > r_full_scale)) begin
                    r_out_duty[k] <= r_full_scale;
                end else begin
                    r_out_duty[k] <= w_quo[k];
                end
            end
        end
    end

    assign o_phase_a_voltage = r_out_v[0];
    assign o_phase_b_voltage = r_out_v[1];
    assign o_phase_c_voltage = r_out_v[2];
    assign o_duty_a          = r_out_duty[0];
    assign o_duty_b          = r_out_duty[1];
    assign o_duty_c          = r_out_duty[2];

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty_a <= r_full_scale) && (o_duty_b <= r_full_scale)
                    && (o_duty_c <= r_full_scale))
        else $error("duty above full scale");

    a_duty_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_phase_a_voltage >= $signed({2'b00, w_vs})) |-> (o_duty_a == 16'd0))
        else $error("phase A at or above supply with nonzero duty");
`endif

endmodule
